// ===== hdl/gsmsp_pkg.sv =====
// Shared types and constants for the GSM septet packer and unpacker.
`timescale 1ns / 1ps

package gsmsp_pkg;

   // Mode register values.
   typedef enum logic {
      DIR_PACK   = 1'b0,
      DIR_UNPACK = 1'b1
   } dir_type;

   // Group position that ends a group of seven octets when unpacking.
   localparam logic [2:0] UnpackGroupEnd = 3'd7;

   // All results that one accepted item causes; the first is always in slot 0.
   typedef struct packed {
      logic [7:0] byte0;
      logic       last0;
      logic [7:0] byte1;
      logic       last1;
      logic       two;
   } entry_type;

   // Queue status seen by the input side and the back.
   typedef struct packed {
      logic valid;
      logic full;
   } qstat_type;

endpackage

// ===== hdl/gsm_septet_pack_unpack_top.sv =====
// Top level of the GSM 7-bit septet packer and unpacker.
`timescale 1ns / 1ps

//  Channel   Ports                                   Role
//  req       req_valid req_stall req_data_byte       byte in: character or octet,
//            req_last_in                             last_in marks the message end
//  rsp       rsp_valid rsp_stall rsp_out_byte        packed octet or septet out,
//            rsp_out_last                            out_last on the final result
//  csr       csr_write_en csr_write_data             mode: 0 packs, 1 unpacks
//
//  An item is accepted every cycle while the two-entry queue has room. An item
//  that yields two results (a pack flush, or the eighth septet of an unpack
//  group) shows them on the output one after the other. The first result of an
//  item passes through the queue and the output register before it is shown.
//  Reset is synchronous and clears the mode, the group position, the leftover
//  bits, the queue and the output valid flag. A stall on rsp holds the output
//  and fills the queue, which then raises req_stall.

module gsm_septet_pack_unpack_top
   import gsmsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_in,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last,

   input  logic       csr_write_en,
   input  logic       csr_write_data
);

   dir_type   direction_ff;
   qstat_type q_status;
   entry_type front_entry;
   entry_type q_data;
   logic      front_push;
   logic      q_pop;
   logic      req_accept;

   // The mode register. The user must write it only while the block is idle; the block itself does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= DIR_PACK;
      end else if (csr_write_en) begin
         direction_ff <= dir_type'(csr_write_data);
      end
   end

   // The input side stalls only when the queue is full.
   assign req_stall  = q_status.full;
   assign req_accept = req_valid && !req_stall;

   // The front keeps the group state and turns each item into an entry that
   // carries all of its results (none, one or two).
   gsmsp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .direction (direction_ff),
      .accept    (req_accept),
      .data_byte (req_data_byte),
      .last_in   (req_last_in),
      .push      (front_push),
      .entry     (front_entry)
   );

   gsmsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_entry),
      .pop       (q_pop),
      .pop_data  (q_data),
      .status    (q_status)
   );

   // The back holds the current entry in its output register and hands out its
   // results in order.
   gsmsp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_status     (q_status),
      .q_data       (q_data),
      .pop          (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

   // The front never writes into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      front_push |-> !q_status.full)
      else $error("entry pushed into a full queue");

   // Reset leaves the output empty.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

   // An entry pushed into an empty pipeline reaches the output through the queue and the output register.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (front_push && !q_status.valid && !rsp_valid) |-> ##2 rsp_valid)
      else $error("result of an idle-time item did not arrive in two cycles");

endmodule

// ===== hdl/gsmsp_front.sv =====
// Front part: accepts items, keeps the group state and builds the result entry.
`timescale 1ns / 1ps

module gsmsp_front
   import gsmsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  dir_type    direction,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       last_in,
   output logic       push,
   output entry_type  entry
);

   logic [2:0]  pos_ff, pos_in;
   logic [6:0]  left_ff, left_in;

   logic [6:0]  chr;
   logic [14:0] pk_shift;
   logic [7:0]  pk_out0;
   logic [6:0]  pk_left;
   logic [2:0]  pk_pos;

   logic [2:0]  up_pos;
   logic [14:0] up_shift;
   logic [7:0]  up_out0;
   logic [7:0]  up_rest;
   logic [2:0]  up_pos_next;

   always_comb begin
      // Pack: the new character fills the top of the octet above the leftover bits.
      chr      = data_byte[6:0];
      pk_shift = {chr, 8'h00} >> pos_ff;
      pk_out0  = pk_shift[7:0] | {1'b0, left_ff};
      pk_left  = (pos_ff == 3'd0) ? chr : (chr >> pos_ff);
      pk_pos   = pos_ff + 3'd1;

      // Unpack: a position left at seven by a mode change counts as zero.
      up_pos      = (pos_ff == UnpackGroupEnd) ? 3'd0 : pos_ff;
      up_shift    = {7'h00, data_byte} << up_pos;
      up_out0     = {1'b0, up_shift[6:0] | left_ff};
      up_rest     = data_byte >> (UnpackGroupEnd - up_pos);
      up_pos_next = up_pos + 3'd1;

      entry   = '0;
      push    = 1'b0;
      pos_in  = pos_ff;
      left_in = left_ff;

      if (direction == DIR_PACK) begin
         if (pos_ff != 3'd0) begin
            entry.byte0 = pk_out0;
            if (last_in && pk_pos != 3'd0) begin
               entry.byte1 = {1'b0, pk_left};
               entry.last1 = 1'b1;
               entry.two   = 1'b1;
            end else begin
               entry.last0 = last_in;
            end
            push = accept;
         end else if (last_in) begin
            // A last character at the start of a group is flushed on its own.
            entry.byte0 = {1'b0, pk_left};
            entry.last0 = 1'b1;
            push        = accept;
         end
         pos_in  = last_in ? 3'd0 : pk_pos;
         left_in = last_in ? 7'd0 : pk_left;
      end else begin
         entry.byte0 = up_out0;
         if (up_pos_next == UnpackGroupEnd) begin
            entry.byte1 = {1'b0, up_rest[6:0]};
            entry.last1 = last_in;
            entry.two   = 1'b1;
            pos_in      = 3'd0;
            left_in     = 7'd0;
         end else begin
            entry.last0 = last_in;
            pos_in      = last_in ? 3'd0 : up_pos_next;
            left_in     = last_in ? 7'd0 : up_rest[6:0];
         end
         push = accept;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 3'd0;
         left_ff <= 7'd0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         left_ff <= left_in;
      end
   end

endmodule

// ===== hdl/gsmsp_queue.sv =====
// Two-entry queue of result entries between the front and the back.
`timescale 1ns / 1ps

module gsmsp_queue
   import gsmsp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   input  logic      pop,
   output entry_type pop_data,
   output qstat_type status
);

   entry_type  mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   assign pop_data     = mem_ff[rd_ptr_ff];
   assign status.valid = (count_ff != 2'd0);
   assign status.full  = (count_ff == 2'd2);

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

// ===== hdl/gsmsp_back.sv =====
// Back part: takes entries from the queue and hands out their results one at a time.
`timescale 1ns / 1ps

module gsmsp_back
   import gsmsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  qstat_type  q_status,
   input  entry_type  q_data,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);

   entry_type ent_ff, ent_in;
   logic      valid_ff, valid_in;
   logic      sel_ff, sel_in;
   logic      take;
   logic      done;

   always_comb begin
      take     = valid_ff && !rsp_stall;
      done     = !ent_ff.two || sel_ff;
      pop      = 1'b0;
      ent_in   = ent_ff;
      valid_in = valid_ff;
      sel_in   = sel_ff;
      if (!valid_ff || (take && done)) begin
         if (q_status.valid) begin
            pop      = 1'b1;
            ent_in   = q_data;
            valid_in = 1'b1;
            sel_in   = 1'b0;
         end else begin
            valid_in = 1'b0;
         end
      end else if (take) begin
         sel_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
      ent_ff <= ent_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = sel_ff ? ent_ff.byte1 : ent_ff.byte0;
   assign rsp_out_last = sel_ff ? ent_ff.last1 : ent_ff.last0;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the GSM septet packer and unpacker top level.
`timescale 1ns / 1ps

module tb_top
   import gsmsp_pkg::*;
;

   // One result on the rsp channel: an octet or a septet, and its message-end flag.
   typedef struct packed {
      logic [7:0] octet;
      logic       msg_end;
   } septet_word_type;

   // Tracks the mode, the group position and the carried bits of the block,
   // predicts the results of every accepted item, and checks the results in order.
   class septet_stream_checker;
      dir_type         mode;
      logic [2:0]      position;
      logic [6:0]      carry_bits;
      septet_word_type expected_words[$];
      int              mismatches;
      int              words_checked;

      function new();
         mode          = DIR_PACK;
         position      = 3'd0;
         carry_bits    = 7'd0;
         mismatches    = 0;
         words_checked = 0;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function void note_accepted_byte(logic [7:0] data, logic msg_end);
         logic [15:0]     wide;
         logic [2:0]      pos;
         logic [6:0]      carry;
         septet_word_type w;
         pos   = position;
         carry = carry_bits;
         if (mode == DIR_PACK) begin
            // The first character of a group of eight only fills the carry.
            if (pos == 3'd0) begin
               carry = data[6:0];
            end else begin
               wide      = ({9'd0, data[6:0]} << (4'd8 - {1'b0, pos})) | {9'd0, carry};
               w.octet   = wide[7:0];
               w.msg_end = 1'b0;
               expected_words.push_back(w);
               wide  = {9'd0, data[6:0]} >> pos;
               carry = wide[6:0];
            end
            pos = pos + 3'd1;
            if (msg_end) begin
               if (pos != 3'd0) begin
                  // Leftover bits go out as a flush octet, as if a zero character followed.
                  w.octet   = {1'b0, carry};
                  w.msg_end = 1'b1;
                  expected_words.push_back(w);
               end else begin
                  w         = expected_words.pop_back();
                  w.msg_end = 1'b1;
                  expected_words.push_back(w);
               end
            end
         end else begin
            // A position left at seven by packing counts as the start of a group.
            if (pos == UnpackGroupEnd) begin
               pos = 3'd0;
            end
            wide      = ({8'd0, data} << pos) | {9'd0, carry};
            w.octet   = {1'b0, wide[6:0]};
            w.msg_end = 1'b0;
            expected_words.push_back(w);
            wide  = {8'd0, data} >> (3'd7 - pos);
            carry = wide[6:0];
            pos   = pos + 3'd1;
            if (pos == UnpackGroupEnd) begin
               // The seventh octet of a group also completes an eighth septet.
               w.octet = {1'b0, carry};
               expected_words.push_back(w);
               pos   = 3'd0;
               carry = 7'd0;
            end
            if (msg_end) begin
               w         = expected_words.pop_back();
               w.msg_end = 1'b1;
               expected_words.push_back(w);
            end
         end
         if (msg_end) begin
            position   = 3'd0;
            carry_bits = 7'd0;
         end else begin
            position   = pos;
            carry_bits = carry;
         end
      endfunction

      function void check_output_byte(logic [7:0] octet, logic msg_end);
         septet_word_type w;
         if (expected_words.size() == 0) begin
            $display("%0t: result with nothing expected: octet %02h last %0b",
                     $time, octet, msg_end);
            mismatches++;
         end else begin
            w = expected_words.pop_front();
            words_checked++;
            if (w.octet !== octet) begin
               $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                        $time, w.octet, octet);
               mismatches++;
            end
            if (w.msg_end !== msg_end) begin
               $display("%0t: out_last mismatch: expected %0b, actual %0b",
                        $time, w.msg_end, msg_end);
               mismatches++;
            end
         end
      endfunction
   endclass

   // Cycles without any accepted item on either channel before the run is abandoned.
   localparam int StuckLimit = 1000;
   // Cycles allowed after the last expected result, since a packed character at the
   // start of a group yields nothing and may still be in the pipeline.
   localparam int SettleCycles = 6;
   // Least number of input items sent over the whole run, directed ones included.
   localparam int TotalItems = 1150;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_data_byte;
   logic       req_last_in;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;
   logic       csr_write_en;
   logic       csr_write_data;

   septet_stream_checker checker_h;
   int   bytes_sent;
   int   mode_writes;
   int   stuck_cycles;
   // While this is set neither side inserts idle cycles or stalls.
   logic no_gaps = 1'b0;

   gsm_septet_pack_unpack_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_last_in    (req_last_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_last   (rsp_out_last),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver stalls about a quarter of the cycles, except in the gap-free stretch.
   always @(negedge clock) begin
      rsp_stall <= !no_gaps && ($urandom_range(99) < 24);
   end

   // Results are checked at the rising edge, and the watchdog counts cycles in which
   // neither channel moves an item.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         checker_h.check_output_byte(rsp_out_byte, rsp_out_last);
      end
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
      end
      if (stuck_cycles >= StuckLimit) begin
         $display("%0t: no progress for %0d cycles", $time, StuckLimit);
         $display("Some tests failed");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after the item is taken.
   // An idle gap comes first now and then.
   task automatic send_item(input logic [7:0] data, input logic msg_end);
      no_gaps = (bytes_sent >= 500) && (bytes_sent < 650);
      if (!no_gaps && ($urandom_range(99) < 14)) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_last_in   <= msg_end;
      do begin
         @(posedge clock);
      end while (req_stall);
      checker_h.note_accepted_byte(data, msg_end);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_run(input logic [7:0] run[$], input logic ends_message);
      foreach (run[i]) begin
         send_item(run[i], ends_message && (i == run.size() - 1));
      end
   endtask

   // Holds the sender until every expected result has come out and the pipeline
   // has had time to settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (checker_h.pending() != 0) begin
         @(posedge clock);
      end
      repeat (SettleCycles) @(posedge clock);
      @(negedge clock);
   endtask

   // The mode is only changed while the block is idle; the group state is kept.
   task automatic set_direction(input dir_type dir);
      drain();
      csr_write_en   <= 1'b1;
      csr_write_data <= dir;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      checker_h.mode = dir;
      mode_writes++;
   endtask

   // A few messages of random content; some phases stop in the middle of a message,
   // so that the next mode starts from a half-finished group.
   task automatic random_phase();
      int         msg_count;
      int         len;
      logic       cut_short;
      logic [7:0] data;
      msg_count = $urandom_range(1, 4);
      cut_short = ($urandom_range(99) < 20);
      for (int m = 0; m < msg_count; m++) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 16);
         for (int k = 0; k < len; k++) begin
            case ($urandom_range(19))
               0:       data = 8'h00;
               1:       data = 8'hff;
               2:       data = 8'h7f;
               3:       data = 8'h80;
               default: data = 8'($urandom_range(255));
            endcase
            send_item(data, (k == len - 1) && !(cut_short && (m == msg_count - 1)));
         end
      end
   endtask

   initial begin
      logic [7:0] run[$];
      int         directed_bytes;
      int         phases;
      dir_type    next_dir;

      checker_h      = new();
      bytes_sent     = 0;
      mode_writes    = 0;
      stuck_cycles   = 0;
      phases         = 0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data_byte  = 8'h00;
      req_last_in    = 1'b0;
      csr_write_en   = 1'b0;
      csr_write_data = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Seven characters leave the packer at position seven; unpacking then treats
      // that position as the start of a group but keeps the carried bits.
      set_direction(DIR_PACK);
      run = '{8'h00, 8'hff, 8'h7f, 8'h80, 8'h55, 8'h2a, 8'h01};
      send_run(run, 1'b0);
      set_direction(DIR_UNPACK);
      run = '{8'hff};
      send_run(run, 1'b1);

      // A one-character message: its own bits form the flush octet.
      set_direction(DIR_PACK);
      run = '{8'h7f};
      send_run(run, 1'b1);
      // A full group of eight whose last character needs no flush octet.
      run = '{8'haa, 8'h55, 8'h33, 8'hcc, 8'h0f, 8'hf0, 8'h81, 8'h7e};
      send_run(run, 1'b1);

      // A full group of seven octets, the last one yielding two septets.
      set_direction(DIR_UNPACK);
      run = '{8'hff, 8'h00, 8'haa, 8'h55, 8'h80, 8'h01, 8'hfe};
      send_run(run, 1'b1);
      // Two octets of an unfinished group, then packing carries on from there.
      run = '{8'hc3, 8'h3c};
      send_run(run, 1'b0);
      set_direction(DIR_PACK);
      run = '{8'h00};
      send_run(run, 1'b1);
      directed_bytes = bytes_sent;

      // Random phases, mostly alternating the mode and now and then keeping it.
      next_dir = DIR_UNPACK;
      while (bytes_sent < TotalItems) begin
         set_direction(next_dir);
         random_phase();
         phases++;
         if ($urandom_range(3) != 0) begin
            next_dir = (next_dir == DIR_PACK) ? DIR_UNPACK : DIR_PACK;
         end
      end

      drain();
      repeat (10) @(posedge clock);

      $display("Sent %0d bytes (%0d directed) over %0d random phases with %0d mode writes;",
               bytes_sent, directed_bytes, phases, mode_writes);
      $display("checked %0d results, packing and unpacking, with mode changes mid-message.",
               checker_h.words_checked);
      if (checker_h.mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
